// File: rtl/dpp_pkg.sv
// ---------------------------------------------------------------------------
// dpp_pkg
// Widths, register indexes and helpers shared by the depth pixel projector.
// ---------------------------------------------------------------------------
package dpp_pkg;

	// Field widths
	localparam int COL_W      = 12;
	localparam int RAW_W      = 32;
	localparam int DEPTH_W    = 20;
	localparam int CTR_W      = 16;
	localparam int INV_W      = 32;
	localparam int UP_W_CFG   = 32;
	localparam int PNT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Datapath widths
	localparam int MAG_W   = 16;            // |16*u - centre|
	localparam int PROD_W  = MAG_W + DEPTH_W; // offset times depth
	localparam int HI_W    = PROD_W - INV_W;  // bits above the low word
	localparam int T_W     = INV_W + HI_W + 1;
	localparam int Q_W     = T_W - 4;
	localparam int COORD_W = Q_W + 1;         // signed projected coordinate
	localparam int UP_W    = COORD_W + 1;     // room to negate

	// Float decode
	localparam int                FP_PROD_W   = 38;   // 24-bit mantissa times 16000
	localparam logic [7:0]        FP_EXP_INF  = 8'hFF;
	localparam logic [7:0]        FP_EXP_LIM  = 8'd150; // at or above: too far
	localparam logic [7:0]        FP_SHIFT_0  = 8'd39;  // shifts this long round to 0
	localparam logic [13:0]       FP_SCALE    = 14'd16000; // metres to 1/16 mm

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_LO    = 3'd0,
		REG_DEPTH_HI    = 3'd1,
		REG_CENTER_COL  = 3'd2,
		REG_CENTER_ROW  = 3'd3,
		REG_INV_FOCAL_X = 3'd4,
		REG_INV_FOCAL_Y = 3'd5,
		REG_MIN_UP      = 3'd6,
		REG_MAX_UP      = 3'd7
	} cfg_idx_t;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic signed [COORD_W-1:0] PNT_MAX = COORD_W'(2147483647);
	localparam logic signed [COORD_W-1:0] PNT_MIN = -PNT_MAX - COORD_W'(1);

	// Clamp a projected coordinate to the 32-bit signed output range
	function automatic logic signed [PNT_W-1:0] sat_pnt(input logic signed [COORD_W-1:0] v);
		logic signed [PNT_W-1:0] r;
		if (v > PNT_MAX) begin
			r = PNT_MAX[PNT_W-1:0];
		end else if (v < PNT_MIN) begin
			r = PNT_MIN[PNT_W-1:0];
		end else begin
			r = v[PNT_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/dpp_if.sv
// ---------------------------------------------------------------------------
// dpp_if
// Valid/ready channels of the depth pixel projector: pixel in, point out,
// configuration writes.
// ---------------------------------------------------------------------------
interface dpp_in_if;
	import dpp_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] pixel_col;
	logic [COL_W-1:0] pixel_row;
	logic [RAW_W-1:0] raw_depth;
	logic             depth_format;

	modport source (output valid, pixel_col, pixel_row, raw_depth, depth_format, input ready);
	modport sink   (input valid, pixel_col, pixel_row, raw_depth, depth_format, output ready);
endinterface

interface dpp_out_if;
	import dpp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [PNT_W-1:0] point_x;
	logic signed [PNT_W-1:0] point_y;
	logic [DEPTH_W-1:0]      point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface dpp_cfg_if;
	import dpp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dpp_axis.sv
// ---------------------------------------------------------------------------
// dpp_axis
// One back-projection axis: |offset| * depth * reciprocal / 2^36, magnitude
// rounded half up, sign restored. Three pipeline stages, shared enable.
// ---------------------------------------------------------------------------
module dpp_axis (
	input  logic                             clk,
	input  logic                             en,
	input  logic [dpp_pkg::MAG_W-1:0]        mag,
	input  logic                             neg,
	input  logic [dpp_pkg::DEPTH_W-1:0]      depth,
	input  logic [dpp_pkg::INV_W-1:0]        inv,
	output logic signed [dpp_pkg::COORD_W-1:0] coord
);
	import dpp_pkg::*;

	logic [PROD_W-1:0]        prod_s3;
	logic                     neg_s3;
	logic [2*INV_W-1:0]       lo_s4;
	logic [HI_W+INV_W-1:0]    hi_s4;
	logic                     neg_s4;
	logic [T_W-1:0]           t_sum;
	logic [T_W-1:0]           t_rnd;
	logic signed [COORD_W-1:0] q_pos;
	logic signed [COORD_W-1:0] coord_s5;

	// s3: offset magnitude times depth
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(mag) * PROD_W'(depth);
			neg_s3  <= neg;
		end
	end

	// s4: both halves of the product times the Q0.32 reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4  <= (2*INV_W)'(prod_s3[INV_W-1:0]) * (2*INV_W)'(inv);
			hi_s4  <= (HI_W+INV_W)'(prod_s3[PROD_W-1:INV_W]) * (HI_W+INV_W)'(inv);
			neg_s4 <= neg_s3;
		end
	end

	// s5: drop 32 fraction bits, round off four more, restore sign
	assign t_sum = T_W'(hi_s4) + T_W'(lo_s4[2*INV_W-1:INV_W]);
	assign t_rnd = t_sum + T_W'(8);
	assign q_pos = $signed({1'b0, t_rnd[T_W-1:4]});

	always_ff @(posedge clk) begin
		if (en) begin
			coord_s5 <= neg_s4 ? -q_pos : q_pos;
		end
	end

	assign coord = coord_s5;

endmodule

// File: rtl/depth_pixel_to_point_projector.sv
// ---------------------------------------------------------------------------
// depth_pixel_to_point_projector
// Back-projects depth pixels to 3-D points with depth and height gating.
// ---------------------------------------------------------------------------
//  channel  dir  words                                   handshake
//  pixel    in   pixel_col, pixel_row, raw_depth, format valid/ready
//  point    out  point_x, point_y, point_z               valid/ready
//  cfg      in   index, data                             valid/ready (ready tied high)
//
//  One pixel per cycle while the output word is taken; a kept point passes six
//  register stages, output register included, before it is valid.
//  Throughput is one word per cycle as every stage moves on one shared enable;
//  the 32x32 reciprocal multipliers sit in stage four.
//  Reset clears all valid bits and loads the registers with their defaults.
//  When the output word is not taken, every stage holds and pixel.ready is low.
// ---------------------------------------------------------------------------
module depth_pixel_to_point_projector #(
	parameter int STRIDE  = 1,
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	dpp_cfg_if.sink     cfg,
	dpp_in_if.sink      pixel,
	dpp_out_if.source   point
);
	import dpp_pkg::*;

	// Stride check by reciprocal: exact floor for 12-bit columns
	localparam int                 RCP_K     = 24;
	localparam logic [RCP_K:0]     STRIDE_RCP = (RCP_K+1)'(((1 << RCP_K) + STRIDE - 1) / STRIDE);
	localparam int                 RCP_PW    = COL_W + RCP_K + 1;
	localparam logic [4:0]         STRIDE_C  = 5'(STRIDE);
	localparam logic [31:0]        DIM_LIM   = 32'(MAX_DIM);

	// Configuration registers
	logic [DEPTH_W-1:0]         depth_lo_q, depth_hi_q;
	logic [CTR_W-1:0]           center_col_q, center_row_q;
	logic [INV_W-1:0]           inv_focal_x_q, inv_focal_y_q;
	logic signed [UP_W_CFG-1:0] min_up_q, max_up_q;

	logic en;

	// Stage 1
	logic                     keep_s1, fmt_s1, fzero_s1, fbig_s1;
	logic [5:0]               fsh_s1;
	logic [FP_PROD_W-1:0]     fp_s1;
	logic [15:0]              mm_s1;
	logic [COL_W-1:0]         u_s1, v_s1, qu_s1, qv_s1;
	logic [MAG_W-1:0]         magx_s1, magy_s1;
	logic                     negx_s1, negy_s1;

	// Stage 2
	logic                     keep_s2;
	logic [DEPTH_W-1:0]       d_s2;
	logic [MAG_W-1:0]         magx_s2, magy_s2;
	logic                     negx_s2, negy_s2;

	// Stages 3..5 (coordinates inside the axis units)
	logic                     keep_s3, keep_s4, keep_s5;
	logic [DEPTH_W-1:0]       d_s3, d_s4, d_s5;
	logic signed [COORD_W-1:0] x_s5, y_s5;

	// Output register
	logic                     out_v_q;
	logic signed [PNT_W-1:0]  x_q, y_q;
	logic [DEPTH_W-1:0]       z_q;

	// Pipeline advances when the output word is free or leaving
	assign en          = !out_v_q || point.ready;
	assign pixel.ready = en;
	assign cfg.ready   = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_lo_q    <= '0;
			depth_hi_q    <= DEPTH_MAX;
			center_col_q  <= '0;
			center_row_q  <= '0;
			inv_focal_x_q <= '0;
			inv_focal_y_q <= '0;
			min_up_q      <= {1'b1, {(UP_W_CFG-1){1'b0}}};
			max_up_q      <= {1'b0, {(UP_W_CFG-1){1'b1}}};
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_DEPTH_LO:    depth_lo_q    <= cfg.data[DEPTH_W-1:0];
				REG_DEPTH_HI:    depth_hi_q    <= cfg.data[DEPTH_W-1:0];
				REG_CENTER_COL:  center_col_q  <= cfg.data[CTR_W-1:0];
				REG_CENTER_ROW:  center_row_q  <= cfg.data[CTR_W-1:0];
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg.data[INV_W-1:0];
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg.data[INV_W-1:0];
				REG_MIN_UP:      min_up_q      <= $signed(cfg.data[UP_W_CFG-1:0]);
				REG_MAX_UP:      max_up_q      <= $signed(cfg.data[UP_W_CFG-1:0]);
				default: ;
			endcase
		end
	end

	// ---- Stage 1: bounds, float pre-checks, mantissa scaling, offsets ----
	logic [7:0]               f_exp;
	logic                     f_bad, dim_ok, mm_zero, keep_in;
	logic [7:0]               f_sh;
	logic signed [CTR_W:0]    offx, offy;
	logic [RCP_PW-1:0]        rcp_u, rcp_v;

	assign f_exp   = pixel.raw_depth[30:23];
	assign f_bad   = (f_exp == FP_EXP_INF) || (f_exp >= FP_EXP_LIM)
	              || (pixel.raw_depth[31] && (pixel.raw_depth[30:0] != '0));
	assign f_sh    = FP_EXP_LIM - f_exp;
	assign mm_zero = (pixel.raw_depth[15:0] == '0);
	assign dim_ok  = ({20'd0, pixel.pixel_col} < DIM_LIM) && ({20'd0, pixel.pixel_row} < DIM_LIM);
	assign keep_in = pixel.valid && dim_ok && (pixel.depth_format ? !f_bad : !mm_zero);

	assign offx = $signed({1'b0, pixel.pixel_col, 4'b0}) - $signed({1'b0, center_col_q});
	assign offy = $signed({1'b0, pixel.pixel_row, 4'b0}) - $signed({1'b0, center_row_q});
	assign rcp_u = RCP_PW'(pixel.pixel_col) * RCP_PW'(STRIDE_RCP);
	assign rcp_v = RCP_PW'(pixel.pixel_row) * RCP_PW'(STRIDE_RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_s1 <= 1'b0;
		end else if (en) begin
			keep_s1 <= keep_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s1   <= pixel.depth_format;
			fzero_s1 <= (f_exp == '0);
			fbig_s1  <= (f_sh >= FP_SHIFT_0);
			fsh_s1   <= f_sh[5:0];
			fp_s1    <= FP_PROD_W'({1'b1, pixel.raw_depth[22:0]}) * FP_PROD_W'(FP_SCALE);
			mm_s1    <= pixel.raw_depth[15:0];
			u_s1     <= pixel.pixel_col;
			v_s1     <= pixel.pixel_row;
			qu_s1    <= rcp_u[RCP_K +: COL_W];
			qv_s1    <= rcp_v[RCP_K +: COL_W];
			negx_s1  <= offx[CTR_W];
			negy_s1  <= offy[CTR_W];
			magx_s1  <= offx[CTR_W] ? MAG_W'(-offx) : MAG_W'(offx);
			magy_s1  <= offy[CTR_W] ? MAG_W'(-offy) : MAG_W'(offy);
		end
	end

	// ---- Stage 2: stride remainder, float rounding shift, depth select ----
	logic [FP_PROD_W:0]       f_sum, f_rnd;
	logic                     f_far, stride_ok;
	logic [DEPTH_W-1:0]       d_f, d_sel;

	assign f_sum = {1'b0, fp_s1} + ((FP_PROD_W+1)'(1) << (fsh_s1 - 6'd1));
	assign f_rnd = f_sum >> fsh_s1;
	assign f_far = !fbig_s1 && (f_rnd[FP_PROD_W:DEPTH_W] != '0);
	assign d_f   = (fzero_s1 || fbig_s1) ? '0 : f_rnd[DEPTH_W-1:0];
	assign d_sel = fmt_s1 ? d_f : {mm_s1, 4'b0};
	assign stride_ok = ({5'd0, u_s1} == 17'(qu_s1) * 17'(STRIDE_C))
	                && ({5'd0, v_s1} == 17'(qv_s1) * 17'(STRIDE_C));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_s2 <= 1'b0;
		end else if (en) begin
			keep_s2 <= keep_s1 && stride_ok && !(fmt_s1 && !fzero_s1 && f_far);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= d_sel;
			magx_s2 <= magx_s1;
			magy_s2 <= magy_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
		end
	end

	// ---- Stages 3..5: depth band gate, projection in the axis units ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_s3 <= 1'b0;
			keep_s4 <= 1'b0;
			keep_s5 <= 1'b0;
		end else if (en) begin
			keep_s3 <= keep_s2 && (d_s2 >= depth_lo_q) && (d_s2 <= depth_hi_q);
			keep_s4 <= keep_s3;
			keep_s5 <= keep_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= d_s2;
			d_s4 <= d_s3;
			d_s5 <= d_s4;
		end
	end

	dpp_axis u_axis_x (
		.clk   (clk),
		.en    (en),
		.mag   (magx_s2),
		.neg   (negx_s2),
		.depth (d_s2),
		.inv   (inv_focal_x_q),
		.coord (x_s5)
	);

	dpp_axis u_axis_y (
		.clk   (clk),
		.en    (en),
		.mag   (magy_s2),
		.neg   (negy_s2),
		.depth (d_s2),
		.inv   (inv_focal_y_q),
		.coord (y_s5)
	);

	// ---- Stage 6: height band on unsaturated -y, saturate, output word ----
	logic signed [UP_W-1:0] up;
	logic                   up_ok;

	assign up    = -(UP_W'(y_s5));
	assign up_ok = (up >= UP_W'(min_up_q)) && (up <= UP_W'(max_up_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= keep_s5 && up_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= sat_pnt(x_s5);
			y_q <= sat_pnt(y_s5);
			z_q <= d_s5;
		end
	end

	assign point.valid   = out_v_q;
	assign point.point_x = x_q;
	assign point.point_y = y_q;
	assign point.point_z = z_q;

	// ---- Checks ----
	// a delivered depth always lies in the configured band
	a_depth_band: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> (point.point_z >= depth_lo_q) && (point.point_z <= depth_hi_q))
		else $error("point outside depth band");

	// a held output freezes every stage's valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({keep_s1, keep_s2, keep_s3, keep_s4, keep_s5, out_v_q}))
		else $error("pipeline moved during stall");

	// zero x reciprocal gives a zero x coordinate
	a_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && (inv_focal_x_q == '0)) |-> (point.point_x == '0))
		else $error("nonzero x with zero reciprocal");

endmodule
